### design/karf_pkg.sv
// Package: types, constants and helpers for the angle/rate Kalman filter.
package karf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 31;
  localparam int unsigned DtW   = 16;
  localparam int unsigned AccW  = 66;

  localparam logic [1:0] RegNoiseAngle = 2'd0;
  localparam logic [1:0] RegNoiseBias  = 2'd1;
  localparam logic [1:0] RegNoiseMeas  = 2'd2;

  localparam logic [RegW-1:0] NoiseAngleRst = 31'd268435;
  localparam logic [RegW-1:0] NoiseBiasRst  = 31'd805306;
  localparam logic [RegW-1:0] NoiseMeasRst  = 31'd8053064;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpForce  = 1'b1;

  typedef enum logic [4:0] {
    StIdle, StRate, StAngMul, StAngAdd, StPbbMul, StInner, StPaaMul, StPaaAdd,
    StPbMul, StPbAdd, StS, StDiv0, StK0, StDiv1, StK1, StY,
    StAngCor, StBiasCor, StPaaCor, StPabCor, StPbaCor, StPbbCor, StOut
  } state_e;

  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic signed [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(signed'(33'sh0_7FFF_FFFF));
    lo = -AccW'(signed'(33'sh0_8000_0000));
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] rshr(input logic signed [AccW-1:0] v,
                                                  input int unsigned n);
    logic signed [AccW-1:0] t;
    t = v + (AccW'(1) <<< (n - 1));
    return t >>> n;
  endfunction

endpackage

### design/kalman_angle_rate_filter.sv
// Top level: two-state angle/bias Kalman filter with a shared multiplier and divider.
//  channel | dir | tdata (low bit up)                                | tuser
//  s_axis  | in  | measured_angle[31:0], measured_rate[63:32], time_step[79:64] | op
//  m_axis  | out | filtered_angle[31:0], estimated_bias[63:32]       | -
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i                    | -
// Update: predict, then two waits on the serial divider for the gains, then correct;
// the correction is skipped when S is not positive. Force: straight from idle to StOut.
// One transaction in flight; s_axis_tready high only in idle. StOut holds while the
// previous result waits in the output register. Reset clears state and loads noise defaults.
module kalman_angle_rate_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // measured_angle, measured_rate, time_step
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // filtered_angle, estimated_bias
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);
  import karf_pkg::*;

  state_e st_q, st_d;
  logic [RegW-1:0] na_q, nb_q, nm_q;
  logic signed [31:0] ang_q, ang_d, bias_q, bias_d, paa_q, paa_d, pab_q, pab_d;
  logic signed [31:0] pba_q, pba_d, pbb_q, pbb_d;
  logic signed [31:0] meas_q, rate_q, k0_q, k0_d, k1_q, k1_d, y_q, y_d, r_q, r_d;
  logic [DtW-1:0] dt_q;
  logic op_q;
  logic signed [AccW-1:0] acc_q, acc_d, pbbdt_q, pbbdt_d;
  logic signed [32:0] ma;
  logic signed [34:0] mb;
  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] s_full;
  logic signed [33:0] s_q, s_d;
  logic out_stall;
  div_req_t dreq;
  div_rsp_t drsp;

  karf_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = (st_q == StIdle);
  assign prod = AccW'(ma) * AccW'(mb);
  assign s_full = AccW'(paa_q) + AccW'({1'b0, nm_q});

  // multiplier operand select
  always_comb begin
    ma = 33'(signed'({1'b0, dt_q}));
    mb = 35'(rate_q);
    case (st_q)
      StAngMul: mb = 35'(r_q);
      StPbbMul: mb = 35'(pbb_q);
      StPaaMul: mb = 35'(signed'(acc_q[34:0]));
      StPbMul:  mb = 35'(signed'({1'b0, nb_q}));
      StAngCor: begin ma = 33'(k0_q); mb = 35'(y_q); end
      StBiasCor: begin ma = 33'(k1_q); mb = 35'(y_q); end
      StPaaCor: begin ma = 33'(k0_q); mb = 35'(paa_q); end
      StPabCor: begin ma = 33'(k0_q); mb = 35'(pab_q); end
      StPbaCor: begin ma = 33'(k1_q); mb = 35'(paa_q); end
      StPbbCor: begin ma = 33'(k1_q); mb = 35'(pab_q); end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:   if (s_axis_tvalid && s_axis_tready)
                  st_d = (s_axis_tuser == OpForce) ? StOut : StRate;
      StRate:   st_d = StAngMul;
      StAngMul: st_d = StAngAdd;
      StAngAdd: st_d = StPbbMul;
      StPbbMul: st_d = StInner;
      StInner:  st_d = StPaaMul;
      StPaaMul: st_d = StPaaAdd;
      StPaaAdd: st_d = StPbMul;
      StPbMul:  st_d = StPbAdd;
      StPbAdd:  st_d = StS;
      StS:      st_d = (s_full > 0) ? StDiv0 : StOut;
      StDiv0:   st_d = StK0;
      StK0:     if (!drsp.busy) st_d = StDiv1;
      StDiv1:   st_d = StK1;
      StK1:     if (!drsp.busy) st_d = StY;
      StY:      st_d = StAngCor;
      StAngCor: st_d = StBiasCor;
      StBiasCor: st_d = StPaaCor;
      StPaaCor: st_d = StPabCor;
      StPabCor: st_d = StPbaCor;
      StPbaCor: st_d = StPbbCor;
      StPbbCor: st_d = StOut;
      StOut:    if (!out_stall) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  always_comb begin
    ang_d = ang_q; bias_d = bias_q; paa_d = paa_q; pab_d = pab_q;
    pba_d = pba_q; pbb_d = pbb_q; k0_d = k0_q; k1_d = k1_q; y_d = y_q; r_d = r_q;
    acc_d = acc_q; pbbdt_d = pbbdt_q; s_d = s_q;
    dreq.start = 1'b0;
    dreq.num = 64'(signed'(paa_q)) <<< 28;
    dreq.den = s_q;
    case (st_q)
      StRate:   r_d = sat32(AccW'(rate_q) - AccW'(bias_q));
      StAngMul: acc_d = rshr(prod, 16);
      StAngAdd: ang_d = sat32(AccW'(ang_q) + acc_q);
      StPbbMul: pbbdt_d = rshr(prod, 16);
      StInner:  acc_d = pbbdt_q - AccW'(pab_q) - AccW'(pba_q) + AccW'({1'b0, na_q});
      StPaaMul: acc_d = rshr(prod, 16);
      StPaaAdd: begin
        paa_d = sat32(AccW'(paa_q) + acc_q);
        pab_d = sat32(AccW'(pab_q) - pbbdt_q);
        pba_d = sat32(AccW'(pba_q) - pbbdt_q);
      end
      StPbMul:  acc_d = rshr(prod, 16);
      StPbAdd:  pbb_d = sat32(AccW'(pbb_q) + acc_q);
      StS:      s_d = s_full[33:0];
      StDiv0:   dreq.start = 1'b1;
      StK0:     if (!drsp.busy) k0_d = sat32(AccW'(drsp.quo));
      StDiv1: begin
        dreq.start = 1'b1;
        dreq.num = 64'(signed'(pba_q)) <<< 28;
      end
      StK1:     if (!drsp.busy) k1_d = sat32(AccW'(drsp.quo));
      StY:      y_d = sat32(AccW'(meas_q) - AccW'(ang_q));
      StAngCor: ang_d = sat32(AccW'(ang_q) + rshr(prod, 28));
      StBiasCor: bias_d = sat32(AccW'(bias_q) + rshr(prod, 28));
      StPaaCor: acc_d = rshr(prod, 28);
      StPabCor: begin
        acc_d = rshr(prod, 28);
        pbbdt_d = acc_q;
      end
      StPbaCor: pba_d = sat32(AccW'(pba_q) - rshr(prod, 28));
      StPbbCor: begin
        pbb_d = sat32(AccW'(pbb_q) - rshr(prod, 28));
        paa_d = sat32(AccW'(paa_q) - pbbdt_q);
        pab_d = sat32(AccW'(pab_q) - acc_q);
      end
      StOut:    if (op_q == OpForce) ang_d = meas_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      na_q <= NoiseAngleRst; nb_q <= NoiseBiasRst; nm_q <= NoiseMeasRst;
      ang_q <= '0; bias_q <= '0; paa_q <= '0; pab_q <= '0; pba_q <= '0; pbb_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      ang_q <= ang_d; bias_q <= bias_d; paa_q <= paa_d; pab_q <= pab_d;
      pba_q <= pba_d; pbb_q <= pbb_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegNoiseAngle: na_q <= cfg_data_i;
          RegNoiseBias:  nb_q <= cfg_data_i;
          RegNoiseMeas:  nm_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == StOut && !out_stall) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    k0_q <= k0_d; k1_q <= k1_d; y_q <= y_d; r_q <= r_d;
    acc_q <= acc_d; pbbdt_q <= pbbdt_d; s_q <= s_d;
    if (st_q == StOut && !out_stall) m_axis_tdata <= {bias_d, ang_d};
    if (s_axis_tvalid && s_axis_tready) begin
      meas_q <= s_axis_tdata[31:0];
      rate_q <= s_axis_tdata[63:32];
      dt_q   <= s_axis_tdata[79:64];
      op_q   <= s_axis_tuser;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_out_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut) |=> m_axis_tvalid) else $error("result lost");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv0) |=> drsp.busy) else $error("divider not started");

endmodule

### design/karf_div.sv
// Iterative restoring divider: signed numerator, unsigned denominator, truncating toward zero.
module karf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  karf_pkg::div_req_t req_i,
  output karf_pkg::div_rsp_t rsp_o
);
  import karf_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [33:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[63]} - {31'd0, den_q};
    if (req_i.start) begin
      quo_d = req_i.num[63] ? 64'(-req_i.num) : 64'(req_i.num);
      den_d = req_i.den;
      neg_d = req_i.num[63];
      rem_d = '0;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = (cnt_q != 7'd0) || req_i.start;
  assign rsp_o.quo  = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule
